[rtl/core/cwpf_pkg.sv]
`default_nettype none
package cwpf_pkg;

    localparam int WIN_RADIUS = 1;
    localparam int WIN = 2 * WIN_RADIUS + 1;
    localparam int WIN_PTS = WIN * WIN;
    localparam int LINES = 2 * WIN_RADIUS;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int QUEUE_DEPTH = 2;

    localparam int COORD_W = 16;
    localparam int POS_W = 10;
    localparam int CNT_W = $clog2(WIN_PTS + 1);
    localparam int DIST_W = 32;
    localparam int DTOT_W = DIST_W + CNT_W;
    localparam int SUM_W = COORD_W + CNT_W;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_FAR_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_START_ROW = 3'd5;

    localparam logic [10:0] RST_FRAME_WIDTH = 11'd512;
    localparam logic [10:0] RST_FRAME_HEIGHT = 11'd424;
    localparam logic [31:0] RST_NEAR_LIMIT = 32'd16777;
    localparam logic [31:0] RST_FAR_LIMIT = 32'd10066330;
    localparam logic [31:0] RST_LOW_FAR_LIMIT = 32'd5872026;
    localparam logic [9:0] RST_LOW_START_ROW = 10'd205;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic signed [COORD_W-1:0] z_coord;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic signed [COORD_W-1:0] z_coord;
        logic                      frame_start;
    } in_item_t;

    typedef struct packed {
        logic                      found;
        logic [POS_W-1:0]          best_row;
        logic [POS_W-1:0]          best_col;
        logic signed [COORD_W-1:0] hand_x;
        logic signed [COORD_W-1:0] hand_y;
        logic signed [COORD_W-1:0] hand_z;
    } out_item_t;

    typedef struct packed {
        logic [10:0] frame_width;
        logic [10:0] frame_height;
        logic [31:0] near_limit;
        logic [31:0] far_limit;
        logic [31:0] low_region_far_limit;
        logic [9:0]  low_region_start_row;
    } cfg_t;

    // One unit of work for the back end: a window snapshot plus frame events.
    typedef struct packed {
        logic                      clear;
        logic                      eval;
        logic                      emit;
        logic                      low_region;
        logic [POS_W-1:0]          row;
        logic [POS_W-1:0]          col;
        point_t [WIN_PTS-1:0]      win;
    } task_t;

endpackage
`default_nettype wire

[rtl/core/cwpf_ram.sv]
`default_nettype none
module cwpf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/core/cwpf_div.sv]
`default_nettype none
module cwpf_div #(
    parameter int NW = 36,
    parameter int DW = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               busy,
    output logic      [NW-1:0] quot
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [NW-1:0] q_reg, q_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW:0]   trial;
    logic          ge;

    // Restoring division, one quotient bit per cycle from the top down.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        den_next = den_reg;
        trial = {rem_reg[DW-1:0], q_reg[NW-1]};
        ge = trial >= {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = CW'(NW);
            rem_next = '0;
            q_next = num;
            den_next = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? trial - {1'b0, den_reg} : trial;
            q_next = {q_reg[NW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg <= q_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule
`default_nettype wire

[rtl/core/cwpf_fifo.sv]
`default_nettype none
module cwpf_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire cwpf_pkg::task_t push_data,
    output logic                 full,
    input  wire logic            pop,
    output cwpf_pkg::task_t      pop_data,
    output logic                 empty
);
    import cwpf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    task_t         mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [NW-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rd_reg];
    assign full = cnt_reg == NW'(DEPTH);
    assign empty = cnt_reg == '0;

endmodule
`default_nettype wire

[rtl/core/cwpf_front.sv]
`default_nettype none
module cwpf_front #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cwpf_pkg::cfg_t     cfg,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire cwpf_pkg::in_item_t in_data,
    output logic                    q_push,
    output cwpf_pkg::task_t         q_data,
    input  wire logic               q_full
);
    import cwpf_pkg::*;

    localparam int CLW = $clog2(MAX_WIDTH);
    localparam int RLW = $clog2(MAX_HEIGHT);
    localparam int LBW = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int PW = $bits(point_t);

    logic           busy_reg, busy_next;
    point_t         pt_reg;
    logic           fs_reg;
    logic [RLW-1:0] it_row_reg;
    logic [CLW-1:0] it_col_reg;
    logic [LBW-1:0] it_base_reg;
    logic [RLW-1:0] cur_row_reg, cur_row_next;
    logic [CLW-1:0] cur_col_reg, cur_col_next;
    logic [LBW-1:0] cur_base_reg, cur_base_next;
    point_t         win_reg [WIN_PTS];
    point_t         win_next [WIN_PTS];

    logic           accept;
    logic [RLW-1:0] acc_row;
    logic [CLW-1:0] acc_col;
    logic [LBW-1:0] acc_base;
    logic [PW-1:0]  rd [LINES];

    logic [31:0]    fw, fh, w_lim, h_lim, crow, ccol;
    logic           row_end, frame_end, eval, low_region;
    logic [LBW:0]   sel;

    assign in_ready = !busy_reg && !q_full;
    assign accept = in_valid && in_ready;
    assign acc_row = in_data.frame_start ? '0 : cur_row_reg;
    assign acc_col = in_data.frame_start ? '0 : cur_col_reg;
    assign acc_base = in_data.frame_start ? '0 : cur_base_reg;

    // One buffer per stored row; the row that the current item replaces rotates.
    for (genvar l = 0; l < LINES; l++)
    begin : g_line
        cwpf_ram #(
            .WIDTH(PW),
            .DEPTH(MAX_WIDTH)
        ) u_line (
            .clk  (clk),
            .we   (busy_reg && (it_base_reg == LBW'(l))),
            .waddr(it_col_reg),
            .wdata(pt_reg),
            .re   (accept),
            .raddr(acc_col),
            .rdata(rd[l])
        );
    end

    always_comb
    begin
        fw = 32'(cfg.frame_width);
        fh = 32'(cfg.frame_height);
        w_lim = (fw < 32'(WIN)) ? 32'(WIN) : ((fw > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : fw);
        h_lim = (fh < 32'(WIN)) ? 32'(WIN) : ((fh > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : fh);
        row_end = (32'(it_col_reg) + 32'd1) >= w_lim;
        frame_end = row_end && ((32'(it_row_reg) + 32'd1) >= h_lim);
        eval = (32'(it_row_reg) >= 32'(LINES)) && (32'(it_col_reg) >= 32'(LINES));
        crow = 32'(it_row_reg) - 32'(WIN_RADIUS);
        ccol = 32'(it_col_reg) - 32'(WIN_RADIUS);
        low_region = crow > 32'(cfg.low_region_start_row);
    end

    always_comb
    begin
        sel = '0;
        for (int a = 0; a < WIN; a++)
        begin
            for (int b = 0; b < WIN - 1; b++)
            begin
                win_next[a * WIN + b] = win_reg[a * WIN + b + 1];
            end
        end
        for (int a = 0; a < LINES; a++)
        begin
            sel = {1'b0, it_base_reg} + (LBW + 1)'(a);
            if (sel >= (LBW + 1)'(LINES))
            begin
                sel = sel - (LBW + 1)'(LINES);
            end
            win_next[a * WIN + WIN - 1] = point_t'(rd[sel[LBW-1:0]]);
        end
        win_next[WIN_PTS - 1] = pt_reg;
    end

    always_comb
    begin
        busy_next = accept;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        cur_base_next = cur_base_reg;
        if (busy_reg)
        begin
            if (!row_end)
            begin
                cur_row_next = it_row_reg;
                cur_col_next = it_col_reg + 1'b1;
                cur_base_next = it_base_reg;
            end
            else if (!frame_end)
            begin
                cur_row_next = it_row_reg + 1'b1;
                cur_col_next = '0;
                cur_base_next = (it_base_reg == LBW'(LINES - 1)) ? '0 : it_base_reg + 1'b1;
            end
            else
            begin
                cur_row_next = '0;
                cur_col_next = '0;
                cur_base_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            cur_base_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            cur_base_reg <= cur_base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pt_reg <= point_t'({in_data.x_coord, in_data.y_coord, in_data.z_coord});
            fs_reg <= in_data.frame_start;
            it_row_reg <= acc_row;
            it_col_reg <= acc_col;
            it_base_reg <= acc_base;
        end
        if (busy_reg)
        begin
            win_reg <= win_next;
        end
    end

    assign q_push = busy_reg && (eval || fs_reg || frame_end);

    always_comb
    begin
        q_data.clear = fs_reg;
        q_data.eval = eval;
        q_data.emit = frame_end;
        q_data.low_region = low_region;
        q_data.row = crow[POS_W-1:0];
        q_data.col = ccol[POS_W-1:0];
        for (int i = 0; i < WIN_PTS; i++)
        begin
            q_data.win[i] = win_next[i];
        end
    end

endmodule
`default_nettype wire

[rtl/core/cwpf_back.sv]
`default_nettype none
module cwpf_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire cwpf_pkg::cfg_t  cfg,
    input  wire logic            q_empty,
    output logic                 q_pop,
    input  wire cwpf_pkg::task_t q_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output cwpf_pkg::out_item_t  out_data
);
    import cwpf_pkg::*;

    localparam int KW = $clog2(WIN_PTS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ = 3'd1;
    localparam logic [2:0] S_ACC = 3'd2;
    localparam logic [2:0] S_MEAN = 3'd3;
    localparam logic [2:0] S_MWAIT = 3'd4;
    localparam logic [2:0] S_CDIV = 3'd5;
    localparam logic [2:0] S_CWAIT = 3'd6;
    localparam logic [2:0] S_OUT = 3'd7;

    logic [2:0]                state_reg, state_next;
    task_t                     task_reg, task_next;
    logic [KW-1:0]             k_reg, k_next;
    logic [DIST_W-1:0]         sq_reg [3];
    logic [DIST_W-1:0]         sq_next [3];
    logic [CNT_W-1:0]          n_reg, n_next;
    logic [DTOT_W-1:0]         dtot_reg, dtot_next;
    logic signed [SUM_W-1:0]   sum_reg [3];
    logic signed [SUM_W-1:0]   sum_next [3];
    logic [DIST_W-1:0]         dmax_reg, dmax_next, dmin_reg, dmin_next;
    point_t                    mx_reg, mx_next, mn_reg, mn_next;
    logic [DIST_W-1:0]         best_mean_reg, best_mean_next;
    logic [POS_W-1:0]          best_row_reg, best_row_next, best_col_reg, best_col_next;
    logic signed [SUM_W-1:0]   best_sum_reg [3];
    logic signed [SUM_W-1:0]   best_sum_next [3];
    logic [CNT_W-1:0]          best_cnt_reg, best_cnt_next;
    logic [1:0]                co_reg, co_next;
    logic [COORD_W-1:0]        hand_reg [3];
    logic [COORD_W-1:0]        hand_next [3];
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_reg, out_next;

    point_t                    p;
    logic signed [COORD_W-1:0] pc [3];
    logic signed [COORD_W-1:0] mxc [3];
    logic signed [COORD_W-1:0] mnc [3];
    logic [DIST_W-1:0]         d;
    logic                      keep;
    logic                      div_start, div_busy;
    logic [DTOT_W-1:0]         div_num, div_quot;
    logic [CNT_W-1:0]          div_den;
    logic signed [SUM_W-1:0]   bs;
    logic                      bs_neg;
    logic [SUM_W-1:0]          bs_mag;
    logic [COORD_W-1:0]        qc;

    cwpf_div #(
        .NW(DTOT_W),
        .DW(CNT_W)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (div_den),
        .busy (div_busy),
        .quot (div_quot)
    );

    always_comb
    begin
        p = task_reg.win[k_reg];
        pc[0] = p.x_coord;
        pc[1] = p.y_coord;
        pc[2] = p.z_coord;
        mxc[0] = mx_reg.x_coord;
        mxc[1] = mx_reg.y_coord;
        mxc[2] = mx_reg.z_coord;
        mnc[0] = mn_reg.x_coord;
        mnc[1] = mn_reg.y_coord;
        mnc[2] = mn_reg.z_coord;
        d = sq_reg[0] + sq_reg[1] + sq_reg[2];
        keep = (d >= cfg.near_limit) && (d <= cfg.far_limit)
            && !(task_reg.low_region && (d > cfg.low_region_far_limit));
        bs = best_sum_reg[co_reg];
        bs_neg = bs[SUM_W-1];
        bs_mag = bs_neg ? SUM_W'(-bs) : SUM_W'(bs);
        qc = div_quot[COORD_W-1:0];
        div_start = ((state_reg == S_MEAN) && (n_reg > CNT_W'(2)))
            || ((state_reg == S_CDIV) && (best_cnt_reg != '0));
        div_num = (state_reg == S_MEAN)
            ? dtot_reg - DTOT_W'(dmax_reg) - DTOT_W'(dmin_reg)
            : DTOT_W'(bs_mag);
        div_den = (state_reg == S_MEAN) ? n_reg - CNT_W'(2) : best_cnt_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        task_next = task_reg;
        k_next = k_reg;
        sq_next = sq_reg;
        n_next = n_reg;
        dtot_next = dtot_reg;
        sum_next = sum_reg;
        dmax_next = dmax_reg;
        dmin_next = dmin_reg;
        mx_next = mx_reg;
        mn_next = mn_reg;
        best_mean_next = best_mean_reg;
        best_row_next = best_row_reg;
        best_col_next = best_col_reg;
        best_sum_next = best_sum_reg;
        best_cnt_next = best_cnt_reg;
        co_next = co_reg;
        hand_next = hand_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        q_pop = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    task_next = q_data;
                    if (q_data.clear)
                    begin
                        best_mean_next = '1;
                        best_row_next = '0;
                        best_col_next = '0;
                        best_sum_next = '{default: '0};
                        best_cnt_next = '0;
                    end
                    k_next = '0;
                    n_next = '0;
                    dtot_next = '0;
                    sum_next = '{default: '0};
                    dmax_next = '0;
                    dmin_next = '1;
                    mx_next = '0;
                    mn_next = '0;
                    co_next = '0;
                    if (q_data.eval)
                    begin
                        state_next = S_SQ;
                    end
                    else if (q_data.emit)
                    begin
                        state_next = S_CDIV;
                    end
                end
            end
            S_SQ:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    sq_next[c] = DIST_W'(pc[c] * pc[c]);
                end
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (keep)
                begin
                    n_next = n_reg + 1'b1;
                    dtot_next = dtot_reg + DTOT_W'(d);
                    for (int c = 0; c < 3; c++)
                    begin
                        sum_next[c] = sum_reg[c] + SUM_W'(pc[c]);
                    end
                    if (d > dmax_reg)
                    begin
                        dmax_next = d;
                        mx_next = p;
                    end
                    if ((n_reg == '0) || (d < dmin_reg))
                    begin
                        dmin_next = d;
                        mn_next = p;
                    end
                end
                if (k_reg == KW'(WIN_PTS - 1))
                begin
                    state_next = S_MEAN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    state_next = S_SQ;
                end
            end
            S_MEAN:
            begin
                if (n_reg > CNT_W'(2))
                begin
                    state_next = S_MWAIT;
                end
                else
                begin
                    state_next = task_reg.emit ? S_CDIV : S_IDLE;
                end
            end
            S_MWAIT:
            begin
                if (!div_busy)
                begin
                    // Ties keep the earlier window.
                    if (div_quot[DIST_W-1:0] < best_mean_reg)
                    begin
                        best_mean_next = div_quot[DIST_W-1:0];
                        best_row_next = task_reg.row;
                        best_col_next = task_reg.col;
                        best_cnt_next = n_reg - CNT_W'(2);
                        for (int c = 0; c < 3; c++)
                        begin
                            best_sum_next[c] = sum_reg[c] - SUM_W'(mxc[c]) - SUM_W'(mnc[c]);
                        end
                    end
                    state_next = task_reg.emit ? S_CDIV : S_IDLE;
                end
            end
            S_CDIV:
            begin
                if (best_cnt_reg == '0)
                begin
                    hand_next = '{default: '0};
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_CWAIT;
                end
            end
            S_CWAIT:
            begin
                if (!div_busy)
                begin
                    // Divide the magnitude, then restore the sign: truncates toward zero.
                    hand_next[co_reg] = bs_neg ? -qc : qc;
                    if (co_reg == 2'd2)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        co_next = co_reg + 1'b1;
                        state_next = S_CDIV;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next.found = best_cnt_reg != '0;
                    out_next.best_row = (best_cnt_reg != '0) ? best_row_reg : '0;
                    out_next.best_col = (best_cnt_reg != '0) ? best_col_reg : '0;
                    out_next.hand_x = hand_reg[0];
                    out_next.hand_y = hand_reg[1];
                    out_next.hand_z = hand_reg[2];
                    best_mean_next = '1;
                    best_row_next = '0;
                    best_col_next = '0;
                    best_sum_next = '{default: '0};
                    best_cnt_next = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            best_mean_reg <= '1;
            best_row_reg <= '0;
            best_col_reg <= '0;
            best_sum_reg <= '{default: '0};
            best_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            best_mean_reg <= best_mean_next;
            best_row_reg <= best_row_next;
            best_col_reg <= best_col_next;
            best_sum_reg <= best_sum_next;
            best_cnt_reg <= best_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        task_reg <= task_next;
        k_reg <= k_next;
        sq_reg <= sq_next;
        n_reg <= n_next;
        dtot_reg <= dtot_next;
        sum_reg <= sum_next;
        dmax_reg <= dmax_next;
        dmin_reg <= dmin_next;
        mx_reg <= mx_next;
        mn_reg <= mn_next;
        co_reg <= co_next;
        hand_reg <= hand_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

endmodule
`default_nettype wire

[rtl/core/closest_window_point_finder.sv]
// Closest window point finder.
// Points enter on in_valid/in_ready in raster order, one transfer per pixel;
// frame_start marks row 0, column 0. Configuration registers are written
// through cfg_valid/cfg_ready/cfg_index/cfg_data, one register per transfer,
// and cfg_ready is always high. At the last pixel of each frame one result
// is offered on out_valid/out_ready.
// The front end handles each pixel as a line buffer read, then the window
// shift and line buffer write, and takes no new pixel until both are done.
// Every interior pixel queues a window for the back end, which squares each
// window point and then filters and accumulates it, one point after another,
// and then waits on the mean division when more than two points survive;
// the two-entry queue lies between the two ends and in_ready drops when it
// is full. The result follows the last pixel after the pending window work
// and up to three coordinate divisions, one per coordinate.
// Reset clears position counters, best window state and the queue and loads
// the default configuration; the line buffers need no clearing. A stalled
// receiver holds the result in the output register while new pixels are
// still taken until the queue fills.
`default_nettype none
module closest_window_point_finder #(
    parameter int MAX_WIDTH = cwpf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cwpf_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire cwpf_pkg::in_item_t                in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output cwpf_pkg::out_item_t                    out_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [cwpf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]                       cfg_data
);
    import cwpf_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  q_push, q_full, q_pop, q_empty;
    task_t q_in, q_out;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:   cfg_next.frame_width = cfg_data[10:0];
                CFG_FRAME_HEIGHT:  cfg_next.frame_height = cfg_data[10:0];
                CFG_NEAR_LIMIT:    cfg_next.near_limit = cfg_data;
                CFG_FAR_LIMIT:     cfg_next.far_limit = cfg_data;
                CFG_LOW_FAR_LIMIT: cfg_next.low_region_far_limit = cfg_data;
                CFG_LOW_START_ROW: cfg_next.low_region_start_row = cfg_data[9:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width <= RST_FRAME_WIDTH;
            cfg_reg.frame_height <= RST_FRAME_HEIGHT;
            cfg_reg.near_limit <= RST_NEAR_LIMIT;
            cfg_reg.far_limit <= RST_FAR_LIMIT;
            cfg_reg.low_region_far_limit <= RST_LOW_FAR_LIMIT;
            cfg_reg.low_region_start_row <= RST_LOW_START_ROW;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cwpf_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data (in_data),
        .q_push  (q_push),
        .q_data  (q_in),
        .q_full  (q_full)
    );

    cwpf_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(q_in),
        .full     (q_full),
        .pop      (q_pop),
        .pop_data (q_out),
        .empty    (q_empty)
    );

    cwpf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_data   (q_out),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

endmodule
`default_nettype wire

[rtl/core/cwpf_checker.sv]
`default_nettype none
module cwpf_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire cwpf_pkg::out_item_t out_data
);

    // A result that is not taken stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result offered right after reset");

    // A not-found result carries no position and no coordinates.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.best_row == 0
            && out_data.best_col == 0 && out_data.hand_x == 0
            && out_data.hand_y == 0 && out_data.hand_z == 0)
        else $error("not-found result has nonzero fields");

    // Window centres are interior, never on the first row or column.
    a_centre_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.found |-> out_data.best_row != 0 && out_data.best_col != 0)
        else $error("window centre on the frame border");

endmodule

bind closest_window_point_finder cwpf_checker u_cwpf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
);
`default_nettype wire
